// ----- rtl/core/mbrf_pkg.sv -----
package mbrf_pkg;

  localparam int unsigned CrcStages = 6;
  localparam int unsigned FrameLen  = 8;
  localparam int unsigned IdxW      = $clog2(FrameLen);

  localparam logic [7:0]  FuncReadHold = 8'h03;
  localparam logic [15:0] CrcInit      = 16'hFFFF;
  localparam logic [15:0] CrcPolyRefl  = 16'hA001;

  // Frame byte positions.
  localparam logic [IdxW-1:0] PosSlave   = 3'd0;
  localparam logic [IdxW-1:0] PosFunc    = 3'd1;
  localparam logic [IdxW-1:0] PosAddrHi  = 3'd2;
  localparam logic [IdxW-1:0] PosAddrLo  = 3'd3;
  localparam logic [IdxW-1:0] PosZero    = 3'd4;
  localparam logic [IdxW-1:0] PosCount   = 3'd5;
  localparam logic [IdxW-1:0] PosCrcLo   = 3'd6;
  localparam logic [IdxW-1:0] PosCrcHi   = 3'd7;

  typedef struct packed {
    logic [7:0]  slave_address;
    logic [15:0] register_address;
    logic [7:0]  register_count;
  } mbrf_req_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } mbrf_rsp_t;

  // One of the six header bytes that the CRC covers.
  function automatic logic [7:0] mbrf_hdr_byte(input mbrf_req_t req,
                                               input logic [IdxW-1:0] pos);
    logic [7:0] b;
    case (pos)
      PosSlave:  b = req.slave_address;
      PosFunc:   b = FuncReadHold;
      PosAddrHi: b = req.register_address[15:8];
      PosAddrLo: b = req.register_address[7:0];
      PosZero:   b = 8'h00;
      PosCount:  b = req.register_count;
      default:   b = 8'h00;
    endcase
    return b;
  endfunction

  // CRC-16/MODBUS update by one byte, least significant bit first.
  function automatic logic [15:0] mbrf_crc_byte(input logic [15:0] crc,
                                                input logic [7:0]  data);
    logic [15:0] acc;
    acc = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CrcPolyRefl;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

endpackage

// ----- rtl/core/modbus_read_request_framer_core.sv -----
// Modbus RTU read-holding-registers request framer.
// A request (slave address, starting register address, register count)
// enters on the req channel when req_valid_i is high and req_stall_o low.
// For each request the block sends eight bytes on the rsp channel, one per
// accepted response: slave address, function code 03h, address high and
// low, a zero byte, the count, then the CRC-16/MODBUS low and high bytes.
// last_byte is set on the CRC high byte.
// The CRC is built in a six-stage pipeline, one header byte per stage, and
// a serialiser then steps through the frame into the output register.
// A request passes through the six CRC stages, the serialiser and the
// output register. The serialiser sends one byte a cycle unless the
// receiver stalls, and takes the next frame as it sends the last byte.
// More requests queue in the pipeline, which takes one whenever it has room.
// When the receiver stalls, the output byte holds and the serialiser and
// pipeline wait; req_stall_o rises once the pipeline is full.
// Reset empties the pipeline, the serialiser and the output register.
module modbus_read_request_framer_core
  import mbrf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_stall_o,
  input  mbrf_req_t req_i,
  output logic      rsp_valid_o,
  input  logic      rsp_stall_i,
  output mbrf_rsp_t rsp_o
);

  logic        pipe_ready;
  logic        pipe_valid;
  mbrf_req_t   pipe_req;
  logic [15:0] pipe_crc;

  logic            ser_valid_q;
  logic [IdxW-1:0] ser_idx_q;
  mbrf_req_t       ser_req_q;
  logic [15:0]     ser_crc_q;

  logic      out_valid_q;
  mbrf_rsp_t out_q;
  mbrf_rsp_t out_d;

  logic out_adv;
  logic ser_emit;
  logic ser_done;
  logic ser_take;

  mbrf_crc_pipe u_crc_pipe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_valid_i),
    .req_i   (req_i),
    .ready_o (pipe_ready),
    .valid_o (pipe_valid),
    .req_o   (pipe_req),
    .crc_o   (pipe_crc),
    .ready_i (ser_take)
  );

  assign req_stall_o = !pipe_ready;

  assign out_adv  = !out_valid_q || !rsp_stall_i;
  assign ser_emit = ser_valid_q && out_adv;
  assign ser_done = ser_emit && (ser_idx_q == PosCrcHi);
  assign ser_take = !ser_valid_q || ser_done;

  always_comb begin
    case (ser_idx_q)
      PosCrcLo: out_d.frame_byte = ser_crc_q[7:0];
      PosCrcHi: out_d.frame_byte = ser_crc_q[15:8];
      default:  out_d.frame_byte = mbrf_hdr_byte(ser_req_q, ser_idx_q);
    endcase
    out_d.last_byte = (ser_idx_q == PosCrcHi);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_valid_q <= 1'b0;
      ser_idx_q   <= PosSlave;
      out_valid_q <= 1'b0;
    end else begin
      if (ser_take) begin
        ser_valid_q <= pipe_valid;
        ser_idx_q   <= PosSlave;
      end else if (ser_emit) begin
        ser_idx_q <= ser_idx_q + IdxW'(1);
      end
      if (out_adv) begin
        out_valid_q <= ser_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_take && pipe_valid) begin
      ser_req_q <= pipe_req;
      ser_crc_q <= pipe_crc;
    end
    if (ser_emit) begin
      out_q <= out_d;
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

endmodule

// ----- rtl/core/mbrf_crc_pipe.sv -----
module mbrf_crc_pipe
  import mbrf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  mbrf_req_t   req_i,
  output logic        ready_o,
  output logic        valid_o,
  output mbrf_req_t   req_o,
  output logic [15:0] crc_o,
  input  logic        ready_i
);

  logic        v_q   [CrcStages];
  mbrf_req_t   req_q [CrcStages];
  logic [15:0] crc_q [CrcStages];

  logic        rdy     [CrcStages];
  logic        src_v   [CrcStages];
  mbrf_req_t   src_req [CrcStages];
  logic [15:0] src_crc [CrcStages];
  logic [15:0] crc_d   [CrcStages];

  // A stage may load when it is empty or its contents move on, so bubbles
  // close up while the far end is stalled.
  always_comb begin
    rdy[CrcStages-1] = !v_q[CrcStages-1] || ready_i;
    for (int i = CrcStages - 2; i >= 0; i--) begin
      rdy[i] = !v_q[i] || rdy[i+1];
    end
  end

  always_comb begin
    src_v[0]   = valid_i;
    src_req[0] = req_i;
    src_crc[0] = CrcInit;
    for (int i = 1; i < CrcStages; i++) begin
      src_v[i]   = v_q[i-1];
      src_req[i] = req_q[i-1];
      src_crc[i] = crc_q[i-1];
    end
    for (int i = 0; i < CrcStages; i++) begin
      crc_d[i] = mbrf_crc_byte(src_crc[i], mbrf_hdr_byte(src_req[i], IdxW'(i)));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CrcStages; i++) begin
        v_q[i] <= 1'b0;
      end
    end else begin
      for (int i = 0; i < CrcStages; i++) begin
        if (rdy[i]) begin
          v_q[i] <= src_v[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CrcStages; i++) begin
      if (rdy[i] && src_v[i]) begin
        req_q[i] <= src_req[i];
        crc_q[i] <= crc_d[i];
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[CrcStages-1];
  assign req_o   = req_q[CrcStages-1];
  assign crc_o   = crc_q[CrcStages-1];

endmodule
